// ===== hdl/spdp_pkg.sv =====
// Shared types and constants for the SMS deliver message parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package spdp_pkg;

  localparam int MAX_ID_DIGITS_DEF = 20;
  localparam int STAMP_DIGITS_DEF  = 14;

  localparam logic [7:0] HDR_BYTE   = 8'h04;
  localparam logic [7:0] TYPE_BYTE  = 8'hc9;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] NIB_MASK   = 8'h0f;

  localparam logic [2:0] K_SENDER = 3'd0;
  localparam logic [2:0] K_STAMP  = 3'd1;
  localparam logic [2:0] K_DLEN   = 3'd2;
  localparam logic [2:0] K_CHAR   = 3'd3;
  localparam logic [2:0] K_DONE   = 3'd4;
  localparam logic [2:0] K_ERROR  = 3'd5;

  // All results caused by one input byte, at most three.
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][2:0] kind;
    logic [2:0][7:0] value;
  } bundle_t;

endpackage

`default_nettype wire

// ===== hdl/sms_deliver_pdu_parser.sv =====
// SMS deliver message parser. Takes one message byte per request (frame_start marks the
// header byte) and returns sender digits, timestamp digits, the septet count, unpacked
// 7-bit characters, then complete or format error; one byte gives 0..3 results. A byte is
// taken when the two-entry bundle queue has room, also while earlier results still wait;
// results leave the output register one per cycle unless out_stall holds them.
// Depends on spdp_pkg, spdp_front, spdp_queue, spdp_back.
`default_nettype none

module sms_deliver_pdu_parser
  import spdp_pkg::*;
#(
  parameter int MAX_ID_DIGITS = MAX_ID_DIGITS_DEF,
  parameter int STAMP_DIGITS  = STAMP_DIGITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] byte_value,
  input  wire logic       frame_start,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      kind,
  output logic [7:0]      value,
  output logic            last_of_run
);

  logic    q_full, push, pop, head_valid;
  bundle_t push_data, head;

  assign in_stall = q_full;

  spdp_front #(
    .MAX_ID_DIGITS (MAX_ID_DIGITS),
    .STAMP_DIGITS  (STAMP_DIGITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .byte_value  (byte_value),
    .frame_start (frame_start),
    .q_full      (q_full),
    .push        (push),
    .push_data   (push_data)
  );

  spdp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  spdp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .value       (value),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

// ===== hdl/spdp_front.sv =====
// Front end: accepts bytes, runs the message parse and builds result bundles.
// Depends on spdp_pkg.
`default_nettype none

module spdp_front
  import spdp_pkg::*;
#(
  parameter int MAX_ID_DIGITS = MAX_ID_DIGITS_DEF,
  parameter int STAMP_DIGITS  = STAMP_DIGITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [7:0] byte_value,
  input  wire logic       frame_start,
  input  wire logic       q_full,
  output logic            push,
  output bundle_t         push_data
);

  localparam int STAMP_BYTES = (STAMP_DIGITS + 1) / 2;
  localparam int SBW         = $clog2(STAMP_BYTES + 1);
  localparam logic STAMP_ODD = (STAMP_DIGITS % 2) != 0;

  typedef enum logic [8:0] {
    PH_IDLE   = 9'b000000001,
    PH_LEN    = 9'b000000010,
    PH_TYPE   = 9'b000000100,
    PH_SENDER = 9'b000001000,
    PH_ZERO1  = 9'b000010000,
    PH_ZERO2  = 9'b000100000,
    PH_STAMP  = 9'b001000000,
    PH_DLEN   = 9'b010000000,
    PH_DATA   = 9'b100000000
  } phase_t;

  phase_t           phase, phase_next;
  logic [7:0]       digits_left, digits_left_next;
  logic [SBW-1:0]   stamp_bytes_left, stamp_bytes_left_next;
  logic [7:0]       septets_left, septets_left_next;
  logic [6:0]       carry_bits, carry_bits_next;
  logic [2:0]       bit_offset, bit_offset_next;
  logic             accept;
  logic [1:0]       n;
  bundle_t          bnd;

  assign accept    = in_valid && !q_full;
  assign push      = accept && (n != 2'd0);
  assign push_data = bnd;

  always_comb begin
    logic [2:0] off;
    logic [6:0] ch;
    logic [7:0] sl;
    logic [7:0] dl;
    phase_next            = phase;
    digits_left_next      = digits_left;
    stamp_bytes_left_next = stamp_bytes_left;
    septets_left_next     = septets_left;
    carry_bits_next       = carry_bits;
    bit_offset_next       = bit_offset;
    n   = 2'd0;
    bnd = '0;
    off = (bit_offset > 3'd6) ? 3'd0 : bit_offset;
    ch  = 7'(((byte_value & (8'h7f >> off)) << off) | {1'b0, carry_bits});
    sl  = septets_left;
    dl  = digits_left;
    if (frame_start) begin
      digits_left_next      = '0;
      stamp_bytes_left_next = '0;
      septets_left_next     = '0;
      carry_bits_next       = '0;
      bit_offset_next       = '0;
      if (byte_value != HDR_BYTE) begin
        bnd.kind[0] = K_ERROR;
        n           = 2'd1;
        phase_next  = PH_IDLE;
      end else begin
        phase_next = PH_LEN;
      end
    end else begin
      unique case (phase)
        PH_IDLE: ;
        PH_LEN: begin
          if (byte_value > 8'(MAX_ID_DIGITS)) begin
            bnd.kind[0] = K_ERROR;
            n           = 2'd1;
            phase_next  = PH_IDLE;
          end else begin
            digits_left_next = byte_value;
            phase_next       = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (byte_value != TYPE_BYTE) begin
            bnd.kind[0] = K_ERROR;
            n           = 2'd1;
            phase_next  = PH_IDLE;
          end else begin
            phase_next = (digits_left == 8'd0) ? PH_ZERO1 : PH_SENDER;
          end
        end
        PH_SENDER: begin
          bnd.kind[0]  = K_SENDER;
          bnd.value[0] = (byte_value & NIB_MASK) + ASCII_ZERO;
          n  = 2'd1;
          dl = dl - 8'd1;
          if (dl != 8'd0) begin
            bnd.kind[1]  = K_SENDER;
            bnd.value[1] = (byte_value >> 4) + ASCII_ZERO;
            n  = 2'd2;
            dl = dl - 8'd1;
          end
          digits_left_next = dl;
          if (dl == 8'd0) phase_next = PH_ZERO1;
        end
        PH_ZERO1: begin
          if (byte_value != ZERO_BYTE) begin
            bnd.kind[0] = K_ERROR;
            n           = 2'd1;
            phase_next  = PH_IDLE;
          end else begin
            phase_next = PH_ZERO2;
          end
        end
        PH_ZERO2: begin
          if (byte_value != ZERO_BYTE) begin
            bnd.kind[0] = K_ERROR;
            n           = 2'd1;
            phase_next  = PH_IDLE;
          end else begin
            stamp_bytes_left_next = SBW'(STAMP_BYTES);
            phase_next = (STAMP_BYTES == 0) ? PH_DLEN : PH_STAMP;
          end
        end
        PH_STAMP: begin
          bnd.kind[0]  = K_STAMP;
          bnd.value[0] = (byte_value & NIB_MASK) + ASCII_ZERO;
          n = 2'd1;
          if (!(stamp_bytes_left == SBW'(1) && STAMP_ODD)) begin
            bnd.kind[1]  = K_STAMP;
            bnd.value[1] = (byte_value >> 4) + ASCII_ZERO;
            n = 2'd2;
          end
          stamp_bytes_left_next = stamp_bytes_left - SBW'(1);
          if (stamp_bytes_left == SBW'(1)) phase_next = PH_DLEN;
        end
        PH_DLEN: begin
          septets_left_next = byte_value;
          carry_bits_next   = '0;
          bit_offset_next   = '0;
          bnd.kind[0]  = K_DLEN;
          bnd.value[0] = byte_value;
          n = 2'd1;
          if (byte_value == 8'd0) begin
            bnd.kind[1] = K_DONE;
            n           = 2'd2;
            phase_next  = PH_IDLE;
          end else begin
            phase_next = PH_DATA;
          end
        end
        PH_DATA: begin
          bnd.kind[0]  = K_CHAR;
          bnd.value[0] = {1'b0, ch};
          n  = 2'd1;
          sl = sl - 8'd1;
          carry_bits_next = 7'(byte_value >> (3'd7 - off));
          bit_offset_next = off + 3'd1;
          if (off == 3'd6) begin
            if (sl != 8'd0) begin
              bnd.kind[1]  = K_CHAR;
              bnd.value[1] = {1'b0, 7'(byte_value >> 1)};
              n  = 2'd2;
              sl = sl - 8'd1;
            end
            carry_bits_next = '0;
            bit_offset_next = '0;
          end
          septets_left_next = sl;
          if (sl == 8'd0) begin
            bnd.kind[n] = K_DONE;
            n           = n + 2'd1;
            phase_next  = PH_IDLE;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
    bnd.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      digits_left      <= '0;
      stamp_bytes_left <= '0;
      septets_left     <= '0;
      carry_bits       <= '0;
      bit_offset       <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      digits_left      <= digits_left_next;
      stamp_bytes_left <= stamp_bytes_left_next;
      septets_left     <= septets_left_next;
      carry_bits       <= carry_bits_next;
      bit_offset       <= bit_offset_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/spdp_queue.sv =====
// Two-entry queue of result bundles between front and back end.
// Depends on spdp_pkg.
`default_nettype none

module spdp_queue
  import spdp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire bundle_t push_data,
  output logic         full,
  input  wire logic    pop,
  output logic         head_valid,
  output bundle_t      head
);

  bundle_t    mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/spdp_back.sv =====
// Back end: unpacks queued bundles into single results behind an output register.
// Depends on spdp_pkg.
`default_nettype none

module spdp_back
  import spdp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    head_valid,
  input  wire bundle_t head,
  output logic         pop,
  output logic         out_valid,
  input  wire logic    out_stall,
  output logic [2:0]   kind,
  output logic [7:0]   value,
  output logic         last_of_run
);

  bundle_t    cur;
  logic       cur_valid;
  logic [1:0] cur_pos;
  logic       adv;
  logic       cur_last;

  assign adv      = !out_valid || !out_stall;
  assign cur_last = cur_valid && (cur_pos == cur.cnt - 2'd1);
  assign pop      = head_valid && (!cur_valid || (adv && cur_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cur_pos   <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= cur_valid;
        if (cur_valid) cur_pos <= cur_pos + 2'd1;
      end
      if (pop) begin
        cur_valid <= 1'b1;
        cur_pos   <= 2'd0;
      end else if (adv && cur_last) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    if (adv && cur_valid) begin
      kind        <= cur.kind[cur_pos];
      value       <= cur.value[cur_pos];
      last_of_run <= cur_last;
    end
  end

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == K_DONE || kind == K_ERROR) |-> last_of_run)
    else $error("done or error result not marked last");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (cur_pos < cur.cnt))
    else $error("bundle position past its count");

  a_no_empty_bundle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (head.cnt != 2'd0))
    else $error("empty bundle in queue");

endmodule

`default_nettype wire
